FILE: rtl/core/u8d_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16LE decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

  typedef enum logic [1:0] {
    ST_UNIT = 2'd0,
    ST_END  = 2'd1,
    ST_FAIL = 2'd2
  } u8d_status_t;

  typedef struct packed {
    u8d_status_t status;
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic        last;
  } u8d_result_t;

  // All results caused by one input byte: one or two.
  typedef struct packed {
    logic        two;
    u8d_result_t first;
    u8d_result_t second;
  } u8d_group_t;

  localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

endpackage
`default_nettype wire

FILE: rtl/core/u8d_if.sv
// Channel interfaces of the decoder: input bytes, results and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface u8d_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] code_unit;
  logic [15:0] unit_count;
  logic        last;
  modport source (output valid, output status, output code_unit, output unit_count,
                  output last, input ready);
  modport sink (input valid, input status, input code_unit, input unit_count,
                input last, output ready);
endinterface

interface u8d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_units;
  modport source (output valid, output max_units, input ready);
  modport sink (input valid, input max_units, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/u8d_decode.sv
// Input byte register and per-byte UTF-8 decode with string state.
`timescale 1ns / 1ps
`default_nettype none
module u8d_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_max_units,
  input  wire logic              q_ready,
  output logic                   grp_valid,
  output u8d_pkg::u8d_group_t    grp
);

  logic        in_full;
  logic [7:0]  byte_q;
  logic [15:0] max_units;
  logic [15:0] partial_unit;
  logic [1:0]  bytes_pending;
  logic        three_byte_seq;
  logic [15:0] units_done;
  logic        skipping_to_nul;

  logic [15:0] partial_unit_next;
  logic [1:0]  bytes_pending_next;
  logic        three_byte_seq_next;
  logic [15:0] units_done_next;
  logic        skipping_to_nul_next;
  logic        has_result;
  logic        fire;

  assign fire     = in_full && q_ready;
  assign in_ready = !in_full || q_ready;

  always_comb begin
    logic [7:0]  c;
    logic [15:0] unit;
    logic [15:0] cnt;
    logic        do_emit;
    logic        do_finish;
    u8d_pkg::u8d_status_t fin_status;

    c         = byte_q;
    unit      = 16'd0;
    do_emit   = 1'b0;
    do_finish = 1'b0;
    fin_status = u8d_pkg::ST_END;
    cnt       = units_done + 16'd1;

    partial_unit_next    = partial_unit;
    bytes_pending_next   = bytes_pending;
    three_byte_seq_next  = three_byte_seq;
    units_done_next      = units_done;
    skipping_to_nul_next = skipping_to_nul;
    has_result           = 1'b0;
    grp                  = '0;

    if (skipping_to_nul) begin
      if (c == 8'd0) begin
        skipping_to_nul_next = 1'b0;
      end
    end else if (bytes_pending != 2'd0) begin
      if (c[7:6] != 2'b10) begin
        do_finish  = 1'b1;
        fin_status = u8d_pkg::ST_FAIL;
      end else if (bytes_pending[1]) begin
        partial_unit_next  = partial_unit | {4'd0, c[5:0], 6'd0};
        bytes_pending_next = 2'd1;
      end else begin
        unit = partial_unit | {10'd0, c[5:0]};
        // Three-byte results in the surrogate range D800-DFFF are rejected.
        if (three_byte_seq && unit[15:11] == 5'b11011) begin
          do_finish  = 1'b1;
          fin_status = u8d_pkg::ST_FAIL;
        end else begin
          do_emit = 1'b1;
        end
      end
    end else if (units_done >= max_units || c == 8'd0) begin
      do_finish  = 1'b1;
      fin_status = u8d_pkg::ST_END;
    end else if (!c[7]) begin
      unit    = {8'd0, c};
      do_emit = 1'b1;
    end else if (c[7:5] == 3'b110) begin
      partial_unit_next   = {5'd0, c[4:0], 6'd0};
      bytes_pending_next  = 2'd1;
      three_byte_seq_next = 1'b0;
    end else if (c[7:4] == 4'b1110) begin
      partial_unit_next   = {c[3:0], 12'd0};
      bytes_pending_next  = 2'd2;
      three_byte_seq_next = 1'b1;
    end else begin
      do_finish  = 1'b1;
      fin_status = u8d_pkg::ST_FAIL;
    end

    if (do_finish) begin
      has_result            = 1'b1;
      grp.first.status      = fin_status;
      grp.first.code_unit   = 16'd0;
      grp.first.unit_count  = units_done;
      grp.first.last        = 1'b1;
      partial_unit_next     = 16'd0;
      bytes_pending_next    = 2'd0;
      three_byte_seq_next   = 1'b0;
      units_done_next       = 16'd0;
      skipping_to_nul_next  = (c != 8'd0);
    end else if (do_emit) begin
      has_result            = 1'b1;
      grp.first.status      = u8d_pkg::ST_UNIT;
      grp.first.code_unit   = unit;
      grp.first.unit_count  = cnt;
      partial_unit_next     = 16'd0;
      bytes_pending_next    = 2'd0;
      three_byte_seq_next   = 1'b0;
      if (cnt >= max_units) begin
        // Limit reached: an end result follows from the same byte.
        grp.two               = 1'b1;
        grp.first.last        = 1'b0;
        grp.second.status     = u8d_pkg::ST_END;
        grp.second.code_unit  = 16'd0;
        grp.second.unit_count = cnt;
        grp.second.last       = 1'b1;
        units_done_next       = 16'd0;
        skipping_to_nul_next  = (c != 8'd0);
      end else begin
        grp.first.last  = 1'b1;
        units_done_next = cnt;
      end
    end
  end

  assign grp_valid = fire && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      max_units       <= u8d_pkg::MAX_UNITS_RESET;
      partial_unit    <= 16'd0;
      bytes_pending   <= 2'd0;
      three_byte_seq  <= 1'b0;
      units_done      <= 16'd0;
      skipping_to_nul <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (cfg_we) begin
        max_units <= cfg_max_units;
      end
      if (fire) begin
        partial_unit    <= partial_unit_next;
        bytes_pending   <= bytes_pending_next;
        three_byte_seq  <= three_byte_seq_next;
        units_done      <= units_done_next;
        skipping_to_nul <= skipping_to_nul_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/u8d_queue.sv
// Result queue: stores one group per byte that has results and hands out its results one per beat.
`timescale 1ns / 1ps
`default_nettype none
module u8d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire u8d_pkg::u8d_group_t push_grp,
  output logic                     push_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output u8d_pkg::u8d_result_t     out_res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u8d_pkg::u8d_group_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          sel;
  logic          pop_beat;
  logic          group_done;
  logic          do_push;
  u8d_pkg::u8d_group_t head;

  assign head       = mem[rd_ptr];
  assign push_ready = (count != FULL_CNT);
  assign do_push    = push && push_ready;
  assign out_valid  = (count != '0);
  assign out_res    = sel ? head.second : head.first;
  assign pop_beat   = out_valid && out_ready;
  assign group_done = pop_beat && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (group_done) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (pop_beat) begin
        sel <= !group_done;
      end
      count <= count + CW'(do_push) - CW'(group_done);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/utf8_to_utf16le_decoder_unit.sv
// Top level of the UTF-8 to UTF-16LE stream decoder.
//
//   Channel     Dir   Payload                                   Beat
//   byte_ch     in    data_byte[7:0]                            one UTF-8 byte
//   result_ch   out   status[1:0] code_unit unit_count last     one result
//   cfg_ch      in    max_units[15:0]                           register write
//
// A byte is registered on acceptance, decoded from that register, and its
// group is then registered into the result queue. One byte is taken every
// cycle while the result queue has room; a byte that hits the unit limit
// makes two results, one per output beat. Reset (rst, synchronous)
// clears the string state, empties the queue and sets max_units to 65535.
// A stall on result_ch fills the queue of QUEUE_DEPTH groups, then the input
// register, and only then drops byte_ch.ready. Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16le_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  u8d_byte_if.sink      byte_ch,
  u8d_result_if.source  result_ch,
  u8d_cfg_if.sink       cfg_ch
);

  logic                 q_ready;
  logic                 grp_valid;
  u8d_pkg::u8d_group_t  grp;
  u8d_pkg::u8d_result_t res;

  // Register writes land now; users write only when idle; block never checks.
  assign cfg_ch.ready = 1'b1;

  // Byte register plus decode; it advances only when the queue can take a group.
  u8d_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (byte_ch.valid),
    .in_ready      (byte_ch.ready),
    .in_byte       (byte_ch.data_byte),
    .cfg_we        (cfg_ch.valid),
    .cfg_max_units (cfg_ch.max_units),
    .q_ready       (q_ready),
    .grp_valid     (grp_valid),
    .grp           (grp)
  );

  // The queue separates decode from the output so a stalled sink does not
  // stop the input until the queue is full.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (grp_valid),
    .push_grp   (grp),
    .push_ready (q_ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_res    (res)
  );

  assign result_ch.status     = res.status;
  assign result_ch.code_unit  = res.code_unit;
  assign result_ch.unit_count = res.unit_count;
  assign result_ch.last       = res.last;

endmodule
`default_nettype wire

FILE: verif/tb_utf8_to_utf16le_decoder_unit.sv
// Self-checking testbench for the UTF-8 to UTF-16LE decoder unit: directed and random strings.
`timescale 1ns / 1ps
module tb_utf8_to_utf16le_decoder_unit;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  // A byte is decoded from the input register after it is taken and may then wait in the
  // result queue, so this many quiet cycles cover any byte still in flight.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BYTES   = 134;

  localparam logic [7:0]  NUL        = 8'h00;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
  localparam logic [7:0]  SURR_LEAD  = 8'hED;
  localparam logic [15:0] SURR_LO    = 16'hD800;
  localparam logic [15:0] SURR_HI    = 16'hDFFF;

  typedef logic [7:0] text_q_t[$];

  // Decoder state kept alongside the block, plus the queue of code units and
  // string endings that the block still owes us.
  class utf16_unit_scoreboard;
    logic [15:0] max_units;
    logic [15:0] partial_unit;
    logic [1:0]  bytes_pending;
    bit          three_byte_seq;
    logic [15:0] units_done;
    bit          skipping;
    u8d_pkg::u8d_result_t expected_units[$];
    int          errors;

    function new();
      max_units      = u8d_pkg::MAX_UNITS_RESET;
      partial_unit   = '0;
      bytes_pending  = '0;
      three_byte_seq = 1'b0;
      units_done     = '0;
      skipping       = 1'b0;
      errors         = 0;
    endfunction

    function void push_result(u8d_pkg::u8d_status_t st, logic [15:0] unit, bit lst);
      u8d_pkg::u8d_result_t r;
      r.status     = st;
      r.code_unit  = unit;
      r.unit_count = units_done;
      r.last       = lst;
      expected_units.push_back(r);
    endfunction

    // End or failure: report the count, clear the string, and skip the rest
    // of the string unless the byte that ended it was the terminator itself.
    function void end_string(u8d_pkg::u8d_status_t st, logic [7:0] c);
      push_result(st, 16'h0000, 1'b1);
      partial_unit   = '0;
      bytes_pending  = '0;
      three_byte_seq = 1'b0;
      units_done     = '0;
      skipping       = (c != NUL);
    endfunction

    function void emit_unit(logic [15:0] unit, logic [7:0] c);
      units_done     = units_done + 16'd1;
      partial_unit   = '0;
      bytes_pending  = '0;
      three_byte_seq = 1'b0;
      if (units_done >= max_units) begin
        push_result(u8d_pkg::ST_UNIT, unit, 1'b0);
        end_string(u8d_pkg::ST_END, c);
      end else begin
        push_result(u8d_pkg::ST_UNIT, unit, 1'b1);
      end
    endfunction

    function void note_byte(logic [7:0] c);
      if (skipping) begin
        if (c == NUL) skipping = 1'b0;
      end else if (bytes_pending != 2'd0) begin
        if ((c & CONT_MASK) != CONT_TAG) begin
          end_string(u8d_pkg::ST_FAIL, c);
        end else if (bytes_pending >= 2'd2) begin
          partial_unit  = partial_unit | {4'h0, c[5:0], 6'h00};
          bytes_pending = 2'd1;
        end else begin
          partial_unit = partial_unit | {10'h000, c[5:0]};
          if (three_byte_seq && partial_unit >= SURR_LO && partial_unit <= SURR_HI) begin
            end_string(u8d_pkg::ST_FAIL, c);
          end else begin
            emit_unit(partial_unit, c);
          end
        end
      end else if (units_done >= max_units || c == NUL) begin
        end_string(u8d_pkg::ST_END, c);
      end else if (c[7] == 1'b0) begin
        emit_unit({8'h00, c}, c);
      end else if ((c & LEAD2_MASK) == LEAD2_TAG) begin
        partial_unit   = {5'h00, c[4:0], 6'h00};
        bytes_pending  = 2'd1;
        three_byte_seq = 1'b0;
      end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
        partial_unit   = {c[3:0], 12'h000};
        bytes_pending  = 2'd2;
        three_byte_seq = 1'b1;
      end else begin
        end_string(u8d_pkg::ST_FAIL, c);
      end
    endfunction

    function void check_result(u8d_pkg::u8d_result_t got);
      u8d_pkg::u8d_result_t want;
      if (expected_units.size() == 0) begin
        $error("unexpected result: status %0d code_unit %h unit_count %0d last %0d",
               got.status, got.code_unit, got.unit_count, got.last);
        errors++;
        return;
      end
      want = expected_units.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.code_unit != want.code_unit) begin
        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.unit_count != want.unit_count) begin
        $error("unit_count: expected %0d, got %0d", want.unit_count, got.unit_count);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  int unsigned cycles = 0;
  int          gap_pct;
  int          stall_pct;

  utf16_unit_scoreboard board;

  u8d_byte_if   byte_ch();
  u8d_result_if result_ch();
  u8d_cfg_if    cfg_ch();

  utf8_to_utf16le_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase. The value
  // changes only at the falling edge, so the block sees it settled.
  always @(negedge clk) begin
    result_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // Every result beat is checked against the oldest outstanding expectation.
  always @(posedge clk) begin : result_monitor
    u8d_pkg::u8d_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status     = u8d_pkg::u8d_status_t'(result_ch.status);
      got.code_unit  = result_ch.code_unit;
      got.unit_count = result_ch.unit_count;
      got.last       = result_ch.last;
      board.check_result(got);
    end
  end

  // Offer one byte, possibly after some idle cycles, and hold it until the
  // block takes it. The predictor is fed at the very edge of acceptance.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      byte_ch.valid     <= 1'b0;
      byte_ch.data_byte <= 8'($urandom);
    end
    @(negedge clk);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    do @(posedge clk); while (!byte_ch.ready);
    board.note_byte(value);
  endtask

  task automatic send_text(input text_q_t text);
    foreach (text[i]) send_byte(text[i]);
  endtask

  // Stop sending and let every owed result drain, then give a byte that
  // produces no result time to pass through before anything else happens.
  task automatic settle();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (board.expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_units(input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.max_units <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.max_units = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed strings with random characters of every width, with a
  // minority of broken sequences and stray bytes mixed in. Always terminated.
  function automatic text_q_t random_text();
    text_q_t    text;
    int         kind;
    logic [7:0] odd;
    repeat ($urandom_range(0, 10)) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        text.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 70) begin
        text.push_back(LEAD2_TAG | 8'($urandom_range(0, 31)));
        text.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
      end else if (kind < 88) begin
        text.push_back(LEAD3_TAG | 8'($urandom_range(0, 15)));
        text.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
        text.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
      end else if (kind < 91) begin
        // Encodes a value in the surrogate range, which must fail.
        text.push_back(SURR_LEAD);
        text.push_back(CONT_TAG | 8'h20 | 8'($urandom_range(0, 31)));
        text.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
      end else if (kind < 94) begin
        if ($urandom_range(0, 1) == 0) text.push_back(8'($urandom_range(128, 191)));
        else text.push_back(8'($urandom_range(240, 255)));
      end else if (kind < 98) begin
        // A sequence cut short by a byte that is not a continuation byte.
        if ($urandom_range(0, 1) == 0) begin
          text.push_back(LEAD2_TAG | 8'($urandom_range(0, 31)));
        end else begin
          text.push_back(LEAD3_TAG | 8'($urandom_range(0, 15)));
          if ($urandom_range(0, 1) == 0) text.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
        end
        odd = 8'($urandom);
        if ((odd & CONT_MASK) == CONT_TAG) odd = odd ^ 8'h40;
        text.push_back(($urandom_range(0, 3) == 0) ? NUL : odd);
      end else begin
        text.push_back(8'($urandom));
      end
    end
    text.push_back(NUL);
    return text;
  endfunction

  initial begin
    text_q_t     text;
    logic [15:0] limit;
    int          sent;
    board               = new();
    rst                 = 1'b1;
    gap_pct             = 0;
    stall_pct           = 0;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'h00;
    cfg_ch.valid        = 1'b0;
    cfg_ch.max_units    = 16'h0000;
    result_ch.ready     = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings at the reset limit. The first one holds the widest value
    // of each sequence length and the smallest two- and three-byte values, overlong forms included.
    text = '{8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
             8'hEF, 8'hBF, 8'hBF, NUL};
    send_text(text);
    // Surrogate value from a three-byte sequence fails.
    text = '{SURR_LEAD, 8'hA0, 8'h80, NUL};
    send_text(text);
    // A bare continuation byte as lead fails; the following letter is skipped.
    text = '{8'h80, 8'h41, NUL};
    send_text(text);
    // Four-byte and invalid lead bytes fail.
    text = '{8'hFF, NUL, 8'hF0, NUL};
    send_text(text);
    // A letter where a continuation byte belongs fails.
    text = '{8'hC2, 8'h41, NUL};
    send_text(text);
    // The terminator in the middle of a sequence fails without skipping, so the
    // letter after it starts a new string.
    text = '{8'hE2, 8'h82, NUL, 8'h42, NUL};
    send_text(text);

    // With a limit of zero a lead byte ends the string at once, and a bare
    // terminator ends it without skipping.
    settle();
    write_max_units(16'h0000);
    text = '{8'h41, NUL, NUL};
    send_text(text);
    // With a limit of one the first unit is followed by an end from the same byte.
    settle();
    write_max_units(16'h0001);
    text = '{8'h41, NUL};
    send_text(text);
    // The limit lowered below the count in the middle of a string.
    settle();
    write_max_units(16'hFFFF);
    text = '{8'h41, 8'h42, 8'h43};
    send_text(text);
    settle();
    write_max_units(16'h0002);
    text = '{8'h44, NUL};
    send_text(text);

    // Random phases, each setting a limit and an idling pattern.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       limit = 16'hFFFF;
        1:       limit = 16'd3;
        2:       limit = 16'd0;
        3:       limit = 16'd1;
        4:       limit = 16'hFFFF;
        5:       limit = 16'($urandom_range(2, 12));
        6:       limit = 16'd5;
        default: limit = 16'hFFFF;
      endcase
      write_max_units(limit);
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 68;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 68;
        end
        default: begin
          gap_pct   = 6;
          stall_pct = 6;
        end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        text = random_text();
        send_text(text);
        sent += text.size();
      end
    end

    settle();
    if (board.errors == 0 && board.expected_units.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
